// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the key classifier rtl
// no dependencies; clock aclk and active-low reset aresetn are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KPHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define KPHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/kphc_pkg.sv -----
// types, codes and defaults for the key press / hold classifier
// no dependencies; used by every rtl module of the block
package kphc_pkg;

    localparam int KEY_W        = 8;
    localparam int TICK_W       = 16;
    localparam int LIMIT_W      = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int NUM_KEYS_DEF = 256;
    localparam int TIME_BITS_DEF = 32;

    // register word index, taken from paddr[2]
    localparam logic CFG_IDX_SMASH_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] SMASH_LIMIT_RST = 32'd100;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } key_state_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_SMASHED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } key_event_t;

    // input beat
    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic              key_down;
        logic [TICK_W-1:0] elapsed_ticks;
    } kphc_in_t;

    // result beat
    typedef struct packed {
        logic [KEY_W-1:0] event_key;
        logic [1:0]       event_kind;
        logic [1:0]       key_state;
    } kphc_out_t;

    // store write controls
    typedef struct packed {
        logic state_we;
        logic press_we;
    } kphc_wr_ctl_t;

    // judge decision for one sample
    typedef struct packed {
        key_state_t new_st;
        key_event_t ev;
        logic       stamp;
    } kphc_verdict_t;

endpackage

// ----- hw/rtl/kphc_cfg.sv -----
// apb register file holding the smash limit
// depends on kphc_pkg
module kphc_cfg import kphc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    smash_limit
);

    logic [LIMIT_W-1:0] smash_limit_reg;
    logic [LIMIT_W-1:0] smash_limit_next;
    logic               hit_limit;

    assign pready    = 1'b1;
    assign hit_limit = (paddr[2] == CFG_IDX_SMASH_LIMIT);

    // write on the access phase
    always_comb begin
        smash_limit_next = smash_limit_reg;
        if (psel && penable && pwrite && hit_limit) begin
            smash_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smash_limit_reg <= SMASH_LIMIT_RST;
        end else begin
            smash_limit_reg <= smash_limit_next;
        end
    end

    // read back
    assign prdata      = hit_limit ? smash_limit_reg : '0;
    assign smash_limit = smash_limit_reg;

endmodule

// ----- hw/rtl/kphc_key_store.sv -----
// per-key state memory and press start memory, registered read
// state memory is swept to free after reset; depends on kphc_pkg
module kphc_key_store import kphc_pkg::*; #(
    parameter int NUM_KEYS  = NUM_KEYS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(NUM_KEYS)-1:0]   rd_addr,
    output key_state_t                    rd_state,
    output logic [TIME_BITS-1:0]          rd_press,
    input  kphc_wr_ctl_t                  wr_ctl,
    input  logic [$clog2(NUM_KEYS)-1:0]   wr_addr,
    input  key_state_t                    wr_state,
    input  logic [TIME_BITS-1:0]          wr_press,
    output logic                          clr_done
);

    localparam int AW = $clog2(NUM_KEYS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_KEYS - 1);

    key_state_t           state_mem [NUM_KEYS];
    logic [TIME_BITS-1:0] press_mem [NUM_KEYS];

    logic [AW-1:0]        clr_addr_reg;
    logic [AW-1:0]        clr_addr_next;
    logic                 clr_done_reg;
    logic                 clr_done_next;
    key_state_t           rd_state_reg;
    logic [TIME_BITS-1:0] rd_press_reg;
    logic                 st_we;
    logic [AW-1:0]        st_addr;
    key_state_t           st_data;

    // clearing sweep, one entry per cycle
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
        end
    end

    // state port mux: sweep owns the port until done
    always_comb begin
        if (!clr_done_reg) begin
            st_we   = 1'b1;
            st_addr = clr_addr_reg;
            st_data = ST_FREE;
        end else begin
            st_we   = wr_ctl.state_we;
            st_addr = wr_addr;
            st_data = wr_state;
        end
    end

    // state memory
    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_addr] <= st_data;
        end
        rd_state_reg <= state_mem[rd_addr];
    end

    // press start memory
    always_ff @(posedge aclk) begin
        if (wr_ctl.press_we) begin
            press_mem[wr_addr] <= wr_press;
        end
        rd_press_reg <= press_mem[rd_addr];
    end

    assign rd_state = rd_state_reg;
    assign rd_press = rd_press_reg;
    assign clr_done = clr_done_reg;

endmodule

// ----- hw/rtl/kphc_judge.sv -----
// next state and event for one key sample
// depends on kphc_pkg
module kphc_judge import kphc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  key_state_t           old_st,
    input  logic                 key_down,
    input  logic [TIME_BITS-1:0] time_now,
    input  logic [TIME_BITS-1:0] press_start,
    input  logic [LIMIT_W-1:0]   smash_limit,
    output kphc_verdict_t        verdict
);

    localparam int CW = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    logic [TIME_BITS-1:0] dur;
    logic                 long_enough;

    // press duration, wraps with the time counter
    assign dur         = time_now - press_start;
    assign long_enough = (CW'(dur) >= CW'(smash_limit));

    always_comb begin
        verdict.new_st = old_st;
        verdict.ev     = EV_NONE;
        verdict.stamp  = 1'b0;
        unique case (old_st)
            ST_FREE: begin
                if (key_down) begin
                    verdict.new_st = ST_PRESSED;
                    verdict.stamp  = 1'b1;
                end
            end
            ST_RELEASED: begin
                if (key_down) begin
                    verdict.new_st = ST_PRESSED;
                    verdict.stamp  = 1'b1;
                    verdict.ev     = EV_SMASHED;
                end
            end
            ST_PRESSED: begin
                if (!key_down) begin
                    verdict.new_st = ST_RELEASED;
                    verdict.ev     = EV_RELEASED;
                end else if (long_enough) begin
                    verdict.new_st = ST_HELD;
                    verdict.ev     = EV_HELD;
                end
            end
            ST_HELD: begin
                if (!key_down) begin
                    verdict.new_st = ST_RELEASED;
                    verdict.ev     = EV_RELEASED;
                end else begin
                    verdict.ev     = EV_HELD;
                end
            end
            default: begin
                verdict.new_st = old_st;
            end
        endcase
    end

endmodule

// ----- hw/rtl/key_press_hold_classifier.sv -----
// top level of the key press / hold classifier: time counter, read-modify-write pipe, output
// depends on kphc_pkg, kphc_cfg, kphc_key_store, kphc_judge and assert_macros.svh
//
//   channel   ports                          beat
//   input     s_valid s_ready s_beat         key_index, key_down, elapsed_ticks
//   result    m_valid m_ready m_beat         event_key, event_kind, key_state
//   config    psel penable pwrite paddr ...  smash_limit at byte address 0
//
// one sample per cycle while m_ready is high; m_valid comes from the output register
// the memory read overlaps the sample capture, then judge and write-back load the output
// back-to-back samples on the same key are forwarded from the write-back stage
// after reset a sweep clears all NUM_KEYS entries of the state memory; s_ready stays low meanwhile
// a stalled result holds the judge stage; s_ready stays high while that stage is free
`include "assert_macros.svh"

module key_press_hold_classifier import kphc_pkg::*; #(
    parameter int NUM_KEYS  = NUM_KEYS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kphc_in_t              s_beat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kphc_out_t             m_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(NUM_KEYS);
    localparam logic [10:0] KEY_LIMIT = 11'(NUM_KEYS);

    logic [LIMIT_W-1:0]   smash_limit;
    logic                 clr_done;
    logic                 accept;
    logic [AW-1:0]        s_addr;
    logic                 s_in_range;
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [KEY_W-1:0]     s1_key_reg;
    logic                 s1_down_reg;
    logic [TIME_BITS-1:0] s1_time_reg;
    logic                 s1_in_range_reg;
    logic [AW-1:0]        s1_addr;
    logic                 s1_adv;

    logic                 fwd_hit_reg;
    key_state_t           fwd_state_reg;
    logic                 fwd_press_hit_reg;
    logic [TIME_BITS-1:0] fwd_press_reg;

    logic [AW-1:0]        rd_addr;
    key_state_t           rd_state;
    logic [TIME_BITS-1:0] rd_press;
    key_state_t           old_st;
    logic [TIME_BITS-1:0] old_press;
    kphc_verdict_t        verdict;
    kphc_wr_ctl_t         wr_ctl;
    kphc_out_t            result;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    kphc_out_t            m_beat_reg;

    // configuration registers
    kphc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .smash_limit (smash_limit)
    );

    // input side
    assign s_addr     = AW'(s_beat.key_index);
    assign s_in_range = ({3'b000, s_beat.key_index} < KEY_LIMIT);
    assign s1_addr    = AW'(s1_key_reg);
    assign s1_adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = clr_done && (!s1_valid_reg || s1_adv);
    assign accept     = s_valid && s_ready;
    assign time_next  = time_reg + TIME_BITS'(s_beat.elapsed_ticks);
    assign s1_valid_next = accept || (s1_valid_reg && !s1_adv);

    // re-read the held key while the judge stage stalls
    assign rd_addr = (s1_valid_reg && !s1_adv) ? s1_addr : s_addr;

    kphc_key_store #(
        .NUM_KEYS  (NUM_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_state (rd_state),
        .rd_press (rd_press),
        .wr_ctl   (wr_ctl),
        .wr_addr  (s1_addr),
        .wr_state (verdict.new_st),
        .wr_press (s1_time_reg),
        .clr_done (clr_done)
    );

    // control registers: time counter and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                time_reg <= time_next;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // judge stage payload and forwarding from the write-back in flight
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_key_reg        <= s_beat.key_index;
            s1_down_reg       <= s_beat.key_down;
            s1_time_reg       <= time_next;
            s1_in_range_reg   <= s_in_range;
            fwd_hit_reg       <= wr_ctl.state_we && (s1_addr == s_addr);
            fwd_state_reg     <= verdict.new_st;
            fwd_press_hit_reg <= wr_ctl.press_we && (s1_addr == s_addr);
            fwd_press_reg     <= s1_time_reg;
        end
    end

    // merge memory data with forwarded data
    assign old_st    = fwd_hit_reg ? fwd_state_reg : rd_state;
    assign old_press = fwd_press_hit_reg ? fwd_press_reg : rd_press;

    kphc_judge #(
        .TIME_BITS (TIME_BITS)
    ) u_judge (
        .old_st      (old_st),
        .key_down    (s1_down_reg),
        .time_now    (s1_time_reg),
        .press_start (old_press),
        .smash_limit (smash_limit),
        .verdict     (verdict)
    );

    // write back when the stage moves on
    assign wr_ctl.state_we = s1_adv && s1_in_range_reg;
    assign wr_ctl.press_we = s1_adv && s1_in_range_reg && verdict.stamp;

    // result beat; keys beyond the store read as free with no event
    always_comb begin
        result.event_key = s1_key_reg;
        if (s1_in_range_reg) begin
            result.event_kind = verdict.ev;
            result.key_state  = verdict.new_st;
        end else begin
            result.event_kind = EV_NONE;
            result.key_state  = ST_FREE;
        end
    end

    // output register
    assign m_valid_next = s1_adv || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_beat_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    // checks
    `KPHC_ASSERT_SAME(a_no_accept_in_sweep, accept, clr_done, "sample taken during clear sweep")
    `KPHC_ASSERT_NEXT(a_stall_keeps_stage, s1_valid_reg && !s1_adv, s1_valid_reg, "judge stage lost a stalled sample")
    `KPHC_ASSERT_SAME(a_stamp_only_on_press, wr_ctl.press_we, verdict.new_st == ST_PRESSED, "press time written outside a new press")
    `KPHC_ASSERT_SAME(a_held_gives_event, m_valid_reg && (m_beat_reg.key_state == ST_HELD), m_beat_reg.event_kind == EV_HELD, "held state without held event")
    `KPHC_ASSERT_SAME(a_no_write_out_of_range, s1_valid_reg && !s1_in_range_reg, !wr_ctl.state_we, "write for key beyond the store")

endmodule
